/* sv/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WordBits  = 32;
   localparam int ChainLen  = 8;
   localparam int Rounds    = 64;
   localparam int BlockBits = 512;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_INDEX = 3'd7;

   localparam logic [31:0] INIT_WORDS [ChainLen] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_EMIT
   } state_type;

   // byte push into the block buffer; last starts the compression
   typedef struct packed {
      logic       push;
      logic       last;
      logic [7:0] data;
   } core_ctrl_type;

   typedef logic [ChainLen-1:0][WordBits-1:0] chain_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
      return (x >> r) | (x << (32 - r));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* sv/sha256_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_core
// Block buffer and one shared compression round, used once per cycle for each
// round of a block. The buffer doubles as the sliding message schedule window.
// ----------------------------------------------------------------------------
module sha256_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::core_ctrl_type ctrl,
   input  sha256_pkg::chain_type     chain,
   output logic                      done,
   output sha256_pkg::chain_type     vars
);

   logic [sha256_pkg::BlockBits-1:0] blk_ff, blk_in;
   sha256_pkg::chain_type            vars_ff, vars_in;
   logic [5:0]                       round_ff, round_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2, ch, maj;

   // window holds w[t] .. w[t+15], w[t] in the top word
   assign w0  = blk_ff[511:480];
   assign w1  = blk_ff[479:448];
   assign w9  = blk_ff[223:192];
   assign w14 = blk_ff[63:32];
   assign w_new = w0 + sha256_pkg::small_sigma0(w1) + w9 + sha256_pkg::small_sigma1(w14);

   // vars[0] is a, vars[7] is h
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^
                (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4]) + ch +
                sha256_pkg::ROUND_K[round_ff] + w0;
   assign t2  = sha256_pkg::big_sigma0(vars_ff[0]) + maj;

   always_comb begin
      blk_in   = blk_ff;
      vars_in  = vars_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.push) begin
         blk_in = {blk_ff[503:0], ctrl.data};
         if (ctrl.last) begin
            busy_in  = 1'b1;
            round_in = '0;
            vars_in  = chain;
         end
      end else if (busy_ff) begin
         blk_in     = {blk_ff[479:0], w_new};
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
         round_in   = round_ff + 6'd1;
         if (round_ff == sha256_pkg::LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_in_hold: begin
         blk_ff  <= blk_in;
         vars_ff <= vars_in;
      end
      if (reset) begin
         round_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         round_ff <= round_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign vars = vars_ff;

endmodule

/* sv/sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream with padding and digest output.
// ----------------------------------------------------------------------------
// An absorb word (mode 0) adds one byte to the block buffer. The word that
// completes a 64-byte block starts its compression: the rounds run on the
// single shared round unit, then the result is folded into the chaining
// words, and no byte is taken meanwhile. A finish word (mode 1) then pushes
// the pad and length bytes one per cycle, pausing while each block is
// compressed (up to 72 bytes over one or two blocks), and emits the digest
// as eight words, index 0 first, one per cycle that rsp_ready is high.
// req_ready is low while a completed block is compressed, and from a finish
// word until the last digest word is taken; after that the hasher starts a
// new message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha256_pkg::state_type     state_ff, state_in;
   sha256_pkg::chain_type     chain_ff, chain_in;
   logic [5:0]                fill_ff, fill_in;
   logic [63:0]               len_ff, len_in;
   logic [63:0]               bits_ff, bits_in;
   logic [2:0]                idx_ff, idx_in;
   logic                      first_ff, first_in;
   logic                      len_phase_ff, len_phase_in;
   logic                      finishing_ff, finishing_in;

   sha256_pkg::core_ctrl_type ctrl;
   sha256_pkg::chain_type     vars;
   logic                      done;

   logic                      req_fire;
   logic                      len_now;
   logic [7:0]                pad_byte;

   sha256_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .chain (chain_ff),
      .done  (done),
      .vars  (vars)
   );

   assign req_fire = req_valid && req_ready;

   // length bytes start once padding reaches offset 56
   assign len_now  = !first_ff && (len_phase_ff || fill_ff == sha256_pkg::LEN_OFFSET);
   assign pad_byte = first_ff ? sha256_pkg::PAD_MARK :
                     (len_now ? bits_ff[63:56] : 8'h00);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_mode) begin
                  state_in = sha256_pkg::ST_PAD;
               end else if (fill_ff == sha256_pkg::LAST_SLOT) begin
                  state_in = sha256_pkg::ST_COMPRESS;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (fill_ff == sha256_pkg::LAST_SLOT) begin
               state_in = sha256_pkg::ST_COMPRESS;
            end
         end
         sha256_pkg::ST_COMPRESS: begin
            if (done) begin
               if (len_phase_ff) begin
                  state_in = sha256_pkg::ST_EMIT;
               end else if (finishing_ff) begin
                  state_in = sha256_pkg::ST_PAD;
               end else begin
                  state_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_ready && idx_ff == sha256_pkg::LAST_INDEX) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctrl      = '0;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.push = req_valid && !req_mode;
            ctrl.last = fill_ff == sha256_pkg::LAST_SLOT;
            ctrl.data = req_data_byte;
         end
         sha256_pkg::ST_PAD: begin
            ctrl.push = 1'b1;
            ctrl.last = fill_ff == sha256_pkg::LAST_SLOT;
            ctrl.data = pad_byte;
         end
         sha256_pkg::ST_COMPRESS: begin
            ctrl = '0;
         end
         sha256_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      chain_in     = chain_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      bits_in      = bits_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      len_phase_in = len_phase_ff;
      finishing_in = finishing_ff;

      if (ctrl.push) begin
         fill_in = fill_ff + 6'd1;
      end
      if (state_ff == sha256_pkg::ST_IDLE && req_fire) begin
         if (req_mode) begin
            bits_in      = {len_ff[60:0], 3'b000};
            first_in     = 1'b1;
            finishing_in = 1'b1;
         end else begin
            len_in = len_ff + 64'd1;
         end
      end
      if (state_ff == sha256_pkg::ST_PAD) begin
         if (first_ff) begin
            first_in = 1'b0;
         end else if (len_now) begin
            bits_in      = {bits_ff[55:0], 8'h00};
            len_phase_in = 1'b1;
         end
      end
      if (state_ff == sha256_pkg::ST_COMPRESS && done) begin
         for (int i = 0; i < sha256_pkg::ChainLen; i++) begin
            chain_in[i] = chain_ff[i] + vars[i];
         end
      end
      if (state_ff == sha256_pkg::ST_EMIT && rsp_ready) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff == sha256_pkg::LAST_INDEX) begin
            for (int i = 0; i < sha256_pkg::ChainLen; i++) begin
               chain_in[i] = sha256_pkg::INIT_WORDS[i];
            end
            len_in       = '0;
            len_phase_in = 1'b0;
            finishing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         for (int i = 0; i < sha256_pkg::ChainLen; i++) begin
            chain_ff[i] <= sha256_pkg::INIT_WORDS[i];
         end
         fill_ff      <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         first_ff     <= 1'b0;
         len_phase_ff <= 1'b0;
         finishing_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         len_phase_ff <= len_phase_in;
         finishing_ff <= finishing_in;
      end
   end

   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = idx_ff == sha256_pkg::LAST_INDEX;

endmodule

/* sv/sha256_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks of the digest output sequence of the hasher.
// ----------------------------------------------------------------------------
module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a held digest word keeps its value and position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word) &&
                                  $stable(rsp_word_index))
      else $error("digest word changed while stalled");

   // no new word is taken while the digest goes out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready during digest output");

   // last word flag marks exactly index 7
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last word flag does not match index");

   // words come out in order with no gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words out of order");

   // the digest ends after its last word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid)
      else $error("output continues after last word");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);
